/* hw/rtl/cbba_pkg.sv */
// ----------------------------------------------------------------------------
// cbba_pkg
// Shared constants, codes and controller/datapath interface types for the
// contiguous bounce buffer allocator.
// ----------------------------------------------------------------------------
package cbba_pkg;

	localparam int POOL_PAGES_DEF    = 64;
	localparam int PAGE_BYTES_DEF    = 4096;
	localparam int RUN_PAGES_MAX_DEF = 16;

	localparam int ADDR_W   = 48;
	localparam int LEN_W    = 16;
	localparam int START_W  = 6;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int AGE_W    = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DMA_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'b1;

	localparam logic CMD_MAP     = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BOUNCED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_RUN  = 2'd3;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE = 4'd0;
	localparam op_t OP_INIT = 4'd1;
	localparam op_t OP_HEAD = 4'd3;
	localparam op_t OP_CAND = 4'd4;
	localparam op_t OP_RD   = 4'd5;
	localparam op_t OP_EV   = 4'd6;
	localparam op_t OP_MARK = 4'd7;
	localparam op_t OP_ADDR = 4'd8;
	localparam op_t OP_REL  = 4'd9;

	typedef logic [2:0] res_t;
	localparam res_t RES_PASS   = 3'd0;
	localparam res_t RES_BOUNCE = 3'd1;
	localparam res_t RES_EMPTY  = 3'd2;
	localparam res_t RES_NORUN  = 3'd3;
	localparam res_t RES_REL    = 3'd4;

	typedef struct packed {
		op_t  op;
		logic capture;
		logic load_out;
		res_t res;
	} cbba_cmd_t;

	typedef struct packed {
		logic init_last;
		logic is_rel;
		logic pass;
		logic head_done;
		logic head_found;
		logic too_long;
		logic loop_end;
		logic cand_fail;
		logic cand_skip;
		logic run_ok;
		logic busy_hit;
		logic mark_done;
		logic rel_done;
	} cbba_stat_t;

endpackage

/* hw/rtl/contiguous_bounce_buffer_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_bounce_buffer_allocator
// Next-fit allocator of contiguous bounce pages for buffers above a DMA limit.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the page busy and free-age
// memories and accepts no transaction until it ends; configuration writes
// are taken throughout. One transaction is worked on at a time. A
// pass-through map goes from the check straight to the result, and a release
// frees its pages one by one (at most RUN_PAGES_MAX). A bounced map first
// scans the free-age memory one page per cycle for the oldest free page, then
// tries each candidate start in turn, probing the run page by page with one
// read of the registered busy memory and one decision per page, confirms the
// run, marks the granted pages busy and forms the bus address. A map that
// finds the pool empty or asks for too long a run ends after the scan. The
// page memories have a single read port. A stalled output holds the result
// in the finish state, and the block returns to idle before it takes the
// next transaction. A new transaction is taken while a result still waits
// in the output register.
module contiguous_bounce_buffer_allocator
	import cbba_pkg::*;
#(
	parameter int POOL_PAGES    = POOL_PAGES_DEF,
	parameter int PAGE_BYTES    = PAGE_BYTES_DEF,
	parameter int RUN_PAGES_MAX = RUN_PAGES_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [ADDR_W-1:0]    phys_addr,
	input  logic [LEN_W-1:0]     total_len,
	input  logic [START_W-1:0]   release_start,
	input  logic [COUNT_W-1:0]   release_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [ADDR_W-1:0]    bus_addr,
	output logic [START_W-1:0]   run_start,
	output logic [COUNT_W-1:0]   run_count
);

	cbba_cmd_t  cmd;
	cbba_stat_t stat;

	cbba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbba_dp #(
		.POOL_PAGES    (POOL_PAGES),
		.PAGE_BYTES    (PAGE_BYTES),
		.RUN_PAGES_MAX (RUN_PAGES_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.phys_addr     (phys_addr),
		.total_len     (total_len),
		.release_start (release_start),
		.release_count (release_count),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.bus_addr      (bus_addr),
		.run_start     (run_start),
		.run_count     (run_count)
	);

endmodule

/* hw/rtl/cbba_dp.sv */
// ----------------------------------------------------------------------------
// cbba_dp
// Datapath: configuration registers, page busy and free-age memories, page
// count rounding, head-scan, run-search and release counters, and the result
// register.
// ----------------------------------------------------------------------------
module cbba_dp
	import cbba_pkg::*;
#(
	parameter int POOL_PAGES    = POOL_PAGES_DEF,
	parameter int PAGE_BYTES    = PAGE_BYTES_DEF,
	parameter int RUN_PAGES_MAX = RUN_PAGES_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 command,
	input  logic [ADDR_W-1:0]    phys_addr,
	input  logic [LEN_W-1:0]     total_len,
	input  logic [START_W-1:0]   release_start,
	input  logic [COUNT_W-1:0]   release_count,
	input  cbba_cmd_t            cmd,
	output cbba_stat_t           stat,
	output logic [STATUS_W-1:0]  status,
	output logic [ADDR_W-1:0]    bus_addr,
	output logic [START_W-1:0]   run_start,
	output logic [COUNT_W-1:0]   run_count
);

	localparam int PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int CW = $clog2(POOL_PAGES + 1);
	localparam int IW = $clog2(2 * POOL_PAGES + RUN_PAGES_MAX + 2);
	localparam int RW = $clog2(RUN_PAGES_MAX + 2);
	localparam int PB = $clog2(PAGE_BYTES);
	localparam int XW = $clog2(64 + RUN_PAGES_MAX + POOL_PAGES + 1);
	localparam int OW = PW + $clog2(PAGE_BYTES + 1);

	logic [ADDR_W-1:0]  dma_limit_q, pool_base_q;
	logic               command_q;
	logic [ADDR_W-1:0]  phys_q;
	logic [LEN_W-1:0]   len_q;
	logic [START_W-1:0] rstart_q;
	logic [RW-1:0]      rcount_q;
	logic [RW-1:0]      r_q;
	logic [CW-1:0]      idx_q;
	logic               hv_s1;
	logic [PW-1:0]      hp_s1;
	logic [PW-1:0]      best_q;
	logic [AGE_W-1:0]   best_age_q;
	logic               found_q;
	logic [IW-1:0]      i_q;
	logic [PW-1:0]      k_q;
	logic [RW-1:0]      j_q, n_q, freed_q;
	logic [AGE_W-1:0]   next_age_q;
	logic [OW-1:0]      off_q;

	logic               busy_mem [POOL_PAGES];
	logic [AGE_W-1:0]   age_mem  [POOL_PAGES];
	logic               busy_rd_q;
	logic [AGE_W-1:0]   age_rd_q;

	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   bus_addr_q;
	logic [START_W-1:0]  run_start_q;
	logic [COUNT_W-1:0]  run_count_q;

	logic [IW-1:0]     k_ext, head_ext, r_ext, probe_ext, mark_ext;
	logic [XW-1:0]     rel_page;
	logic              rel_in;
	logic [ADDR_W:0]   end_sum;
	logic              idx_in;
	logic [LEN_W:0]    len_up, pages_full;
	logic [PW-1:0]     rd_addr, wr_addr;
	logic              busy_we, busy_wd, age_we;

	assign k_ext      = (i_q >= IW'(POOL_PAGES)) ? i_q - IW'(POOL_PAGES) : i_q;
	assign head_ext   = IW'(best_q);
	assign r_ext      = IW'(r_q);
	assign probe_ext  = IW'(k_q) + IW'(j_q);
	assign mark_ext   = IW'(k_q) + IW'(n_q);
	assign rel_page   = XW'(rstart_q) + XW'(n_q);
	assign rel_in     = rel_page < XW'(POOL_PAGES);
	assign end_sum    = {1'b0, phys_q} + (ADDR_W + 1)'(len_q);
	assign idx_in     = idx_q < CW'(POOL_PAGES);
	assign len_up     = {1'b0, total_len} + (LEN_W + 1)'(PAGE_BYTES - 1);
	assign pages_full = len_up >> PB;

	always_comb begin
		stat.init_last  = idx_q == CW'(POOL_PAGES - 1);
		stat.is_rel     = command_q == CMD_RELEASE;
		stat.pass       = end_sum < {1'b0, dma_limit_q};
		stat.head_done  = (idx_q == CW'(POOL_PAGES)) && !hv_s1;
		stat.head_found = found_q;
		stat.too_long   = r_q > RW'(RUN_PAGES_MAX);
		stat.loop_end   = i_q >= IW'(POOL_PAGES) + head_ext;
		stat.cand_fail  = (k_ext < head_ext) && (k_ext + r_ext > head_ext + IW'(1));
		stat.cand_skip  = (k_ext >= head_ext) && (k_ext + r_ext > IW'(POOL_PAGES));
		stat.run_ok     = j_q == r_q;
		stat.busy_hit   = busy_rd_q;
		stat.mark_done  = n_q == r_q;
		stat.rel_done   = n_q == rcount_q;
	end

	always_comb begin
		rd_addr = (cmd.op == OP_HEAD) ? idx_q[PW-1:0] : probe_ext[PW-1:0];
		wr_addr = idx_q[PW-1:0];
		busy_we = 1'b0;
		busy_wd = 1'b0;
		age_we  = 1'b0;
		case (cmd.op)
			OP_INIT: begin
				busy_we = 1'b1;
				age_we  = 1'b1;
			end
			OP_MARK: begin
				wr_addr = mark_ext[PW-1:0];
				busy_we = !stat.mark_done;
				busy_wd = 1'b1;
			end
			OP_REL: begin
				wr_addr = rel_page[PW-1:0];
				busy_we = !stat.rel_done && rel_in;
				age_we  = !stat.rel_done && rel_in;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (busy_we) begin
			busy_mem[wr_addr] <= busy_wd;
		end
		if (age_we) begin
			age_mem[wr_addr] <= (cmd.op == OP_INIT) ? AGE_W'(idx_q) : next_age_q;
		end
		busy_rd_q <= busy_mem[rd_addr];
		age_rd_q  <= age_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_limit_q <= {ADDR_W{1'b1}};
			pool_base_q <= '0;
			idx_q       <= '0;
			hv_s1       <= 1'b0;
			next_age_q  <= AGE_W'(POOL_PAGES);
		end else begin
			if (cfg_we && cfg_index == REG_DMA_LIMIT) begin
				dma_limit_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_POOL_BASE) begin
				pool_base_q <= cfg_data;
			end
			hv_s1 <= (cmd.op == OP_HEAD) && idx_in;
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.op == OP_INIT || (cmd.op == OP_HEAD && idx_in)) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.op == OP_REL && !stat.rel_done && rel_in) begin
				next_age_q <= next_age_q + AGE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		hp_s1 <= idx_q[PW-1:0];
		if (cmd.capture) begin
			command_q <= command;
			phys_q    <= phys_addr;
			len_q     <= total_len;
			rstart_q  <= release_start;
			if (int'(release_count) > RUN_PAGES_MAX) begin
				rcount_q <= RW'(RUN_PAGES_MAX);
			end else begin
				rcount_q <= RW'(release_count);
			end
			if (pages_full > (LEN_W + 1)'(RUN_PAGES_MAX)) begin
				r_q <= RW'(RUN_PAGES_MAX + 1);
			end else begin
				r_q <= RW'(pages_full);
			end
			found_q <= 1'b0;
			n_q     <= '0;
			freed_q <= '0;
		end
		case (cmd.op)
			OP_HEAD: begin
				if (hv_s1 && !busy_rd_q && (!found_q || age_rd_q < best_age_q)) begin
					best_q     <= hp_s1;
					best_age_q <= age_rd_q;
					found_q    <= 1'b1;
				end
				if (stat.head_done) begin
					i_q <= IW'(best_q);
				end
			end
			OP_CAND: begin
				if (stat.cand_skip) begin
					i_q <= IW'(POOL_PAGES);
				end else begin
					k_q <= k_ext[PW-1:0];
					j_q <= '0;
				end
			end
			OP_EV: begin
				if (busy_rd_q) begin
					i_q <= i_q + IW'(j_q) + IW'(1);
				end else begin
					j_q <= j_q + RW'(1);
				end
			end
			OP_MARK: begin
				if (!stat.mark_done) begin
					n_q <= n_q + RW'(1);
				end
			end
			OP_ADDR: begin
				off_q <= OW'(k_q) * OW'(PAGE_BYTES);
			end
			OP_REL: begin
				if (!stat.rel_done) begin
					n_q <= n_q + RW'(1);
					if (rel_in) begin
						freed_q <= freed_q + RW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			unique case (cmd.res)
				RES_PASS: begin
					status_q    <= ST_OK;
					bus_addr_q  <= phys_q;
					run_start_q <= '0;
					run_count_q <= '0;
				end
				RES_BOUNCE: begin
					status_q    <= ST_BOUNCED;
					bus_addr_q  <= pool_base_q + ADDR_W'(off_q);
					run_start_q <= START_W'(k_q);
					run_count_q <= COUNT_W'(r_q);
				end
				RES_EMPTY: begin
					status_q    <= ST_EMPTY;
					bus_addr_q  <= '0;
					run_start_q <= '0;
					run_count_q <= '0;
				end
				RES_REL: begin
					status_q    <= ST_OK;
					bus_addr_q  <= '0;
					run_start_q <= rstart_q;
					run_count_q <= COUNT_W'(freed_q);
				end
				default: begin
					status_q    <= ST_NO_RUN;
					bus_addr_q  <= '0;
					run_start_q <= '0;
					run_count_q <= '0;
				end
			endcase
		end
	end

	assign status    = status_q;
	assign bus_addr  = bus_addr_q;
	assign run_start = run_start_q;
	assign run_count = run_count_q;

	a_probe_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RD && !stat.run_ok) |-> (probe_ext < IW'(POOL_PAGES)))
		else $error("run probe outside pool");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RD || cmd.op == OP_EV) |-> (j_q <= r_q))
		else $error("run probe offset beyond run length");

	a_mark_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MARK && !stat.mark_done) |-> (mark_ext < IW'(POOL_PAGES)))
		else $error("mark outside pool");

endmodule

/* hw/rtl/cbba_ctrl.sv */
// ----------------------------------------------------------------------------
// cbba_ctrl
// Controller: sequences the clearing pass, map and release transactions and
// hands finished results to the output register.
// ----------------------------------------------------------------------------
module cbba_ctrl
	import cbba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  cbba_stat_t stat,
	output cbba_cmd_t  cmd
);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_HEAD  = 4'd4;
	localparam logic [3:0] S_CAND  = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_EV    = 4'd7;
	localparam logic [3:0] S_MARK  = 4'd8;
	localparam logic [3:0] S_ADDR  = 4'd9;
	localparam logic [3:0] S_REL   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0] state_q, state_d;
	res_t       res_q, res_d;
	logic       out_valid_q;

	always_comb begin
		state_d      = state_q;
		res_d        = res_q;
		cmd.op       = OP_NONE;
		cmd.capture  = 1'b0;
		cmd.load_out = 1'b0;
		cmd.res      = res_q;
		unique case (state_q)
			S_INIT: begin
				cmd.op = OP_INIT;
				if (stat.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.is_rel) begin
					state_d = S_REL;
				end else if (stat.pass) begin
					res_d   = RES_PASS;
					state_d = S_FIN;
				end else begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.op = OP_HEAD;
				if (stat.head_done) begin
					if (!stat.head_found) begin
						res_d   = RES_EMPTY;
						state_d = S_FIN;
					end else if (stat.too_long) begin
						res_d   = RES_NORUN;
						state_d = S_FIN;
					end else begin
						state_d = S_CAND;
					end
				end
			end
			S_CAND: begin
				cmd.op = OP_CAND;
				if (stat.loop_end || stat.cand_fail) begin
					res_d   = RES_NORUN;
					state_d = S_FIN;
				end else if (!stat.cand_skip) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.op = OP_RD;
				state_d = stat.run_ok ? S_MARK : S_EV;
			end
			S_EV: begin
				cmd.op = OP_EV;
				state_d = stat.busy_hit ? S_CAND : S_RD;
			end
			S_MARK: begin
				cmd.op = OP_MARK;
				if (stat.mark_done) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.op  = OP_ADDR;
				res_d   = RES_BOUNCE;
				state_d = S_FIN;
			end
			S_REL: begin
				cmd.op = OP_REL;
				if (stat.rel_done) begin
					res_d   = RES_REL;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.load_out = !out_valid_q || out_ready;
				if (cmd.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			res_q       <= RES_PASS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_capture_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_CHECK))
		else $error("accepted transaction not dispatched");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result raised outside finish");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !out_ready) |=> (state_q == S_FIN))
		else $error("finished result dropped while output stalled");

endmodule
